@@ rtl/bpt_pkg.sv @@
// Shared types and constants for the breakpoint table.
package bpt_pkg;

  // Width of the running occupied-slot count carried by the command token.
  localparam int CNT_W = 7;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CHECK  = 3'd4
  } opcode_t;

  // Command token that walks the row of slot cells.
  typedef struct packed {
    logic             valid;
    opcode_t          op;
    logic [15:0]      addr;
    logic             done;
    logic             hit;
    logic [CNT_W-1:0] count;
  } tok_t;

endpackage

@@ rtl/bpt_cell.sv @@
// One slot of the breakpoint table and its share of each command.
module bpt_cell
  import bpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tok_t        tok_in,
  input  logic        rot_en,
  input  logic [15:0] rot_in,
  output tok_t        tok_out,
  output logic [15:0] slot
);

  tok_t        tok_next;
  logic [15:0] slot_next;

  // Apply the passing command to this slot and update the token.
  always_comb begin
    tok_next  = tok_in;
    slot_next = slot;
    if (rot_en) begin
      slot_next = rot_in;
    end else if (tok_in.valid) begin
      unique case (tok_in.op)
        OP_ADD: begin
          if (!tok_in.done) begin
            if (slot == tok_in.addr) begin
              tok_next.done = 1'b1;
            end else if (slot == 16'd0) begin
              slot_next     = tok_in.addr;
              tok_next.done = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (slot == tok_in.addr) slot_next = 16'd0;
        end
        OP_CLEAR: begin
          slot_next = 16'd0;
        end
        OP_QUERY: begin
          if (slot != 16'd0) tok_next.count = tok_in.count + CNT_W'(1);
        end
        OP_CHECK: begin
          if (slot != 16'd0 && slot == tok_in.addr) tok_next.hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Slot storage and the registered hand-off to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= 16'd0;
      tok_out.valid <= 1'b0;
    end else begin
      slot          <= slot_next;
      tok_out.valid <= tok_next.valid;
    end
    tok_out.op    <= tok_next.op;
    tok_out.addr  <= tok_next.addr;
    tok_out.done  <= tok_next.done;
    tok_out.hit   <= tok_next.hit;
    tok_out.count <= tok_next.count;
  end

endmodule

@@ rtl/breakpoint_table_top.sv @@
// Top level of the breakpoint table: cell row, command sequencer and result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: opcode, address
//  m_*       out  m_tvalid/m_tready  m_tdata: status, hit, entry_count, entry_address;
//                                    m_tlast: last
//
// A command token walks the row of SLOT_COUNT cells, one cell per cycle, and the
// result stage then loads the result, so s_tready stays low from each accepted
// item until the sequencer is idle again, and no new item is taken meanwhile.
// The result stage also waits while an earlier result is still held on m_tready.
// A query with occupied slots then rotates the slots once through the row to list
// them; a rotation step waits while an occupied head slot cannot be output yet.
// Reset empties every slot at once; no clearing pass is needed.
// The result register frees the input side while a result waits on m_tready.
module breakpoint_table_top
  import bpt_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [2:0] opcode, [18:3] address, [23:19] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] status, [1] hit, [6:2] entry_count,
                                 // [22:7] entry_address, [23] zero
  output logic        m_tlast
);

  localparam int RW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_OUT  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  tok_t              inject;
  tok_t              tok_o [SLOT_COUNT];
  logic [15:0]       slot_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] tok_vld;
  logic              tok_busy;
  tok_t              fin;
  logic              rot_en;
  logic [RW-1:0]     rot_cnt;
  logic [CNT_W-1:0]  remaining;
  logic              out_free;
  logic              in_acc;
  logic [15:0]       head;

  assign s_tready = (state == S_IDLE) && !rst;
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign head     = slot_q[0];
  assign tok_busy = |tok_vld;

  // Fresh token for an accepted item.
  always_comb begin
    inject.valid = in_acc;
    inject.op    = opcode_t'(s_tdata[2:0]);
    inject.addr  = s_tdata[18:3];
    inject.done  = 1'b0;
    inject.hit   = 1'b0;
    inject.count = '0;
  end

  // Row of slot cells; rotation hands each slot toward cell zero.
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    bpt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  ((i == 0) ? inject : tok_o[(i + SLOT_COUNT - 1) % SLOT_COUNT]),
      .rot_en  (rot_en),
      .rot_in  (slot_q[(i + 1) % SLOT_COUNT]),
      .tok_out (tok_o[i]),
      .slot    (slot_q[i])
    );
    assign tok_vld[i] = tok_o[i].valid;
  end

  // While listing, one rotation step whenever the head needs no output or the output is free.
  assign rot_en = (state == S_EMIT) && (head == 16'd0 || out_free);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_WALK;
      S_WALK: if (tok_o[SLOT_COUNT-1].valid) state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          if (fin.op == OP_QUERY && fin.count != '0) state_next = S_EMIT;
          else state_next = S_IDLE;
        end
      end
      S_EMIT: if (rot_en && rot_cnt == RW'(SLOT_COUNT - 1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Finished token, rotation count and entries still to list.
  always_ff @(posedge clk) begin
    if (state == S_WALK && tok_o[SLOT_COUNT-1].valid) fin <= tok_o[SLOT_COUNT-1];
    if (state == S_OUT) begin
      rot_cnt   <= '0;
      remaining <= fin.count;
    end else if (rot_en) begin
      rot_cnt <= rot_cnt + RW'(1);
      if (head != 16'd0) remaining <= remaining - CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT && out_free) || (rot_en && head != 16'd0)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == S_OUT && out_free) begin
      m_tdata[0]    <= (fin.op == OP_ADD) && !fin.done;
      m_tdata[1]    <= (fin.op == OP_CHECK) && fin.hit;
      m_tdata[6:2]  <= (fin.op == OP_QUERY) ? fin.count[4:0] : 5'd0;
      m_tdata[22:7] <= 16'd0;
      m_tdata[23]   <= 1'b0;
      m_tlast       <= !(fin.op == OP_QUERY && fin.count != '0);
    end else if (rot_en && head != 16'd0) begin
      m_tdata[6:0]  <= 7'd0;
      m_tdata[22:7] <= head;
      m_tdata[23]   <= 1'b0;
      m_tlast       <= (remaining == CNT_W'(1));
    end
  end

`ifndef NO_ASSERTIONS
  // The slot ring never rotates while a command token is in the row.
  a_rot_no_tok: assert property (@(posedge clk) disable iff (rst)
    rot_en |-> !tok_busy)
    else $error("rotation while a token is in flight");

  // No item is taken while a token is still walking the row.
  a_idle_no_tok: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !tok_busy)
    else $error("input ready with token in flight");

  // Listing an occupied slot always has an entry left in the count.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (rot_en && head != 16'd0) |-> remaining != '0)
    else $error("more occupied slots than counted");

  // A token that reaches the end of the row moves the sequencer to the result stage.
  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && tok_o[SLOT_COUNT-1].valid) |=> state == S_OUT)
    else $error("token end not followed by result stage");
`endif

endmodule

@@ test/tb_breakpoint_table_top.sv @@
// Self-checking testbench for the breakpoint table with a built-in table predictor.
module tb_breakpoint_table_top;
  import bpt_pkg::*;

  localparam int SLOT_COUNT = 16;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS = 340;
  localparam int POOL_SIZE = 20;
  localparam int MAX_GAP = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 4 * SLOT_COUNT;

  // Opcodes outside the command set; the block must answer them with a bare last flag.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] addr;
  } table_cmd_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [4:0]  count;
    logic [15:0] addr;
    logic        last;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  table_cmd_t    cmd_queue[$];
  table_cmd_t    cur_cmd;
  table_result_t pending_results[$];
  logic [15:0]   bp_slots[SLOT_COUNT];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            send_wait = 0;
  int            recv_wait = 0;
  logic          send_steady = 1'b0;
  logic          recv_steady = 1'b0;

  breakpoint_table_top #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Free-running clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Update the shadow table for one accepted command and queue the results it causes.
  function automatic void apply_table_command(logic [2:0] op, logic [15:0] addr);
    table_result_t r;
    logic          done;
    int            occupied;
    int            k;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_ADD: begin
        // An equal entry ends the scan before a later hole could be reached.
        done = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!done && bp_slots[i] == addr) begin
            done = 1'b1;
          end else if (!done && bp_slots[i] == '0) begin
            bp_slots[i] = addr;
            done = 1'b1;
          end
        end
        r.status = !done;
        pending_results.push_back(r);
      end
      OP_REMOVE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (bp_slots[i] == addr) bp_slots[i] = '0;
        end
        pending_results.push_back(r);
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) bp_slots[i] = '0;
        pending_results.push_back(r);
      end
      OP_QUERY: begin
        occupied = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (bp_slots[i] != '0) occupied++;
        end
        r.count = occupied[4:0];
        r.last = (occupied == 0);
        pending_results.push_back(r);
        k = 1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (bp_slots[i] != '0) begin
            r = '0;
            r.addr = bp_slots[i];
            r.last = (k == occupied);
            pending_results.push_back(r);
            k++;
          end
        end
      end
      OP_CHECK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (bp_slots[i] != '0 && bp_slots[i] == addr) r.hit = 1'b1;
        end
        pending_results.push_back(r);
      end
      default: begin
        pending_results.push_back(r);
      end
    endcase
  endfunction

  function automatic int draw_gap(logic steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic push_cmd(logic [2:0] op, logic [15:0] addr);
    table_cmd_t c;
    c.op = op;
    c.addr = addr;
    cmd_queue.push_back(c);
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Input side: present queued items, with a random gap after each accepted item.
  always @(posedge clk) begin
    logic busy;
    table_cmd_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_wait = 0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_table_command(cur_cmd.op, cur_cmd.addr);
        busy = 1'b0;
        if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
        send_wait = draw_gap(send_steady);
      end
      if (!busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (cmd_queue.size() > 0) begin
          nxt = cmd_queue.pop_front();
          cur_cmd = nxt;
          s_tdata <= {5'b0, nxt.addr, nxt.op};
          busy = 1'b1;
        end
      end
      s_tvalid <= busy;
    end
  end

  // Output side: check each accepted item, with a random gap after each accepted item.
  always @(posedge clk) begin
    logic rdy;
    table_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      rdy = m_tready;
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
                   $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, m_tdata[0]);
          compare_field("hit", want.hit, m_tdata[1]);
          compare_field("entry_count", want.count, m_tdata[6:2]);
          compare_field("entry_address", want.addr, m_tdata[22:7]);
          compare_field("tdata padding", 0, m_tdata[23]);
          compare_field("last", want.last, m_tlast);
        end
        rdy = 1'b0;
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        recv_wait = draw_gap(recv_steady);
      end
      if (!rdy) begin
        if (recv_wait > 0) recv_wait--;
        else rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_breakpoint_table_top: FAIL");
      $finish;
    end
  end

  // Build the stimulus, release reset, then wait for the table to drain.
  initial begin
    logic [15:0] pool[POOL_SIZE];
    logic [15:0] a;
    logic [2:0]  op;
    int          len;
    int          roll;

    for (int i = 0; i < SLOT_COUNT; i++) bp_slots[i] = '0;

    // Directed part: empty table, field extremes, duplicate beyond a hole, spare opcodes.
    push_cmd(OP_QUERY, 16'h0000);
    push_cmd(OP_CHECK, 16'h0000);
    push_cmd(OP_ADD, 16'h0000);
    push_cmd(OP_REMOVE, 16'h0000);
    push_cmd(OP_ADD, 16'hFFFF);
    push_cmd(OP_ADD, 16'h0001);
    push_cmd(OP_ADD, 16'hFFFF);
    push_cmd(OP_ADD, 16'h8000);
    push_cmd(OP_ADD, 16'h5555);
    push_cmd(OP_ADD, 16'hAAAA);
    push_cmd(OP_QUERY, 16'hFFFF);
    push_cmd(OP_REMOVE, 16'h0001);
    push_cmd(OP_ADD, 16'h8000);
    push_cmd(OP_CHECK, 16'h8000);
    push_cmd(OP_CHECK, 16'hFFFF);
    push_cmd(OP_CHECK, 16'h1234);
    push_cmd(OP_QUERY, 16'h0000);
    push_cmd(OP_REMOVE, 16'h8000);
    push_cmd(OP_CHECK, 16'h8000);
    push_cmd(OP_SPARE_LO, 16'hFFFF);
    push_cmd(OP_SPARE_MID, 16'h5555);
    push_cmd(OP_SPARE_HI, 16'hFFFF);
    push_cmd(OP_QUERY, 16'h0000);
    push_cmd(OP_CLEAR, 16'hFFFF);
    push_cmd(OP_QUERY, 16'h0000);

    // Random part: episodes over a small address pool so that adds, removes and
    // checks collide; some episodes fill the table to the full condition first.
    while (cmd_queue.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = 16'($urandom_range(1, 16'hFFFF));
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < POOL_SIZE; i++) push_cmd(OP_ADD, pool[i]);
        push_cmd(OP_ADD, 16'h0000);
        push_cmd(OP_QUERY, 16'($urandom()));
      end
      len = $urandom_range(8, 40);
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) a = 16'h0000;
        else if (roll < 20) a = 16'($urandom());
        else a = pool[$urandom_range(0, POOL_SIZE - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 40) op = OP_ADD;
        else if (roll < 55) op = OP_REMOVE;
        else if (roll < 80) op = OP_CHECK;
        else if (roll < 92) op = OP_QUERY;
        else if (roll < 95) op = OP_CLEAR;
        else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        push_cmd(op, a);
      end
      push_cmd(OP_QUERY, 16'($urandom()));
      if ($urandom_range(0, 1) == 0) push_cmd(OP_CLEAR, 16'($urandom()));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("tb_breakpoint_table_top: PASS");
    end else begin
      $display("tb_breakpoint_table_top: FAIL");
    end
    $finish;
  end

endmodule
